// ===== hdl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// shared types, command and status codes for the connection slot table
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int SLOTS_DEF     = 64;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 3;
   localparam int ID_W          = 7;
   localparam int PORT_W        = 16;
   localparam int IP_W          = 64;
   localparam int PROTO_W       = 8;
   localparam int BYTES_W       = 16;
   localparam int BUF_W         = 20;
   localparam int GEN_W         = 32;
   localparam int REJ_W         = 32;
   localparam int QUOTA_W       = 7;
   localparam int CAP_W         = 21;
   localparam int CSR_W         = 21;
   localparam int CSR_IDX_W     = 1;
   localparam logic [CAP_W-1:0] BUF_LIMIT = 21'h100000;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PER_IP   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BUFFERED = 1'b1;

   localparam logic [CMD_W-1:0] CMD_CLAIM   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FIND    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEPOSIT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONSUME = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_QUOTA     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVER_CAP  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request beat
      logic scan_clr;   // clear scan results, point at slot 0
      logic scan_rd;    // read slot at scan pointer
      logic scan_eval;  // evaluate read slot
      logic addr_rd;    // read addressed slot
      logic exec;       // apply the command
      logic fin_rd;     // read reported slot
      logic respond;    // drive response beat
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;  // evaluated slot was the last
      logic is_scan;    // command needs a table scan
   } sts_type;

endpackage

// ===== hdl/cst_ctrl.sv =====
// ----------------------------------------------------------------------------
// cst_ctrl
// command sequencer: scan loop, slot read, execute, respond
// ----------------------------------------------------------------------------
module cst_ctrl
   import cst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output ctl_type ctl,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SREAD, S_SEVAL, S_AREAD, S_EXEC, S_FREAD, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.scan_clr = 1'b1;
            state_in = sts.is_scan ? S_SREAD : S_AREAD;
         end
         S_SREAD: begin
            ctl.scan_rd = 1'b1;
            state_in = S_SEVAL;
         end
         S_SEVAL: begin
            ctl.scan_eval = 1'b1;
            state_in = sts.scan_last ? S_EXEC : S_SREAD;
         end
         S_AREAD: begin
            ctl.addr_rd = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = S_FREAD;
         end
         S_FREAD: begin
            ctl.fin_rd = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            ctl.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hdl/cst_dp.sv =====
// ----------------------------------------------------------------------------
// cst_dp
// slot memories, valid bits, scan compare and command execution
// ----------------------------------------------------------------------------
module cst_dp
   import cst_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [PORT_W-1:0]    req_host_port,
   input  logic [IP_W-1:0]      req_remote_ip_high,
   input  logic [IP_W-1:0]      req_remote_ip_low,
   input  logic [PORT_W-1:0]    req_peer_port,
   input  logic [PROTO_W-1:0]   req_protocol,
   input  logic [ID_W-1:0]      req_slot_id,
   input  logic [BYTES_W-1:0]   req_byte_count,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ID_W-1:0]      rsp_slot_index,
   output logic [PORT_W-1:0]    rsp_entry_host_port,
   output logic [IP_W-1:0]      rsp_entry_ip_high,
   output logic [IP_W-1:0]      rsp_entry_ip_low,
   output logic [PORT_W-1:0]    rsp_entry_peer_port,
   output logic [PROTO_W-1:0]   rsp_entry_protocol,
   output logic [BUF_W-1:0]     rsp_buffered_level,
   output logic [GEN_W-1:0]     rsp_slot_generation,
   output logic [ID_W-1:0]      rsp_active_slots,
   output logic [REJ_W-1:0]     rsp_rejected_total
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] NONE = CW'(SLOTS);

   typedef struct packed {
      logic [PORT_W-1:0]  lp;
      logic [IP_W-1:0]    ih;
      logic [IP_W-1:0]    il;
      logic [PORT_W-1:0]  rp;
      logic [PROTO_W-1:0] pr;
   } tuple_type;

   // memories: tuple, buffered count, generation; reset values come from
   // the valid-written bits below
   tuple_type         tup_mem [SLOTS];
   logic [BUF_W-1:0]  buf_mem [SLOTS];
   logic [GEN_W-1:0]  gen_mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff;
   logic [SLOTS-1:0]  tw_ff;    // tuple ever written
   logic [SLOTS-1:0]  bw_ff;    // buffered ever written
   logic [SLOTS-1:0]  gw_ff;    // generation ever written

   logic [QUOTA_W-1:0]  quota_ff;
   logic [CAP_W-1:0]    cap_ff;
   logic [REJ_W-1:0]    rej_ff;
   logic [CW-1:0]       active_ff;

   logic [CMD_W-1:0]    cmd_ff;
   tuple_type           qt_ff;
   logic [ID_W-1:0]     id_ff;
   logic [BYTES_W-1:0]  bytes_ff;

   logic [AW-1:0]       ptr_ff;
   logic [CW-1:0]       ipcnt_ff;
   logic                dup_ff, hit_ff, free_ok_ff;
   logic [AW-1:0]       hit_ff_idx, free_idx_ff;
   logic [GEN_W-1:0]    free_gen_ff;  // generation of the first free slot

   tuple_type           rt_ff;
   logic [BUF_W-1:0]    rb_ff;
   logic [GEN_W-1:0]    rg_ff;
   logic                rv_ff, rtw_ff, rbw_ff, rgw_ff;
   logic [AW-1:0]       raddr_ff;

   logic [STATUS_W-1:0] st_ff;
   logic                rep_ff;
   logic [AW-1:0]       rep_idx_ff;

   logic                id_ok;
   logic [AW-1:0]       id_a;
   logic [AW-1:0]       rd_addr;
   logic                rd_en;
   tuple_type           rt_eff;
   logic [BUF_W-1:0]    rb_eff;
   logic [GEN_W-1:0]    rg_eff;
   logic                eq_ip, eq_full, eq_port;
   logic [CAP_W-1:0]    cap_sat;
   logic [CAP_W-1:0]    dep_sum;
   logic [ID_W-1:0]     next_start;

   assign id_ok = ({{(32-ID_W){1'b0}}, id_ff} < 32'(SLOTS));
   assign id_a  = id_ff[AW-1:0];
   assign next_start = id_ff + ID_W'(1);

   assign sts.is_scan   = (cmd_ff == CMD_CLAIM) || (cmd_ff == CMD_FIND) || (cmd_ff == CMD_NEXT);
   assign sts.scan_last = (ptr_ff == AW'(SLOTS - 1));

   // one shared read port
   always_comb begin
      rd_addr = ptr_ff;
      rd_en   = ctl.scan_rd;
      if (ctl.addr_rd) begin
         rd_addr = id_a;
         rd_en   = 1'b1;
      end else if (ctl.fin_rd) begin
         rd_addr = rep_idx_ff;
         rd_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rt_ff    <= tup_mem[rd_addr];
         rb_ff    <= buf_mem[rd_addr];
         rg_ff    <= gen_mem[rd_addr];
         rv_ff    <= valid_ff[rd_addr];
         rtw_ff   <= tw_ff[rd_addr];
         rbw_ff   <= bw_ff[rd_addr];
         rgw_ff   <= gw_ff[rd_addr];
         raddr_ff <= rd_addr;
      end
   end

   assign rt_eff = rtw_ff ? rt_ff : '0;
   assign rb_eff = rbw_ff ? rb_ff : '0;
   assign rg_eff = rgw_ff ? rg_ff : '0;

   assign eq_ip   = rv_ff && (rt_eff.ih == qt_ff.ih) && (rt_eff.il == qt_ff.il);
   assign eq_full = eq_ip && (rt_eff.lp == qt_ff.lp) && (rt_eff.rp == qt_ff.rp)
                    && (rt_eff.pr == qt_ff.pr);
   assign eq_port = rv_ff && (rt_eff.lp == qt_ff.lp) && (rt_eff.pr == qt_ff.pr);

   assign cap_sat = (cap_ff > BUF_LIMIT) ? BUF_LIMIT : cap_ff;
   assign dep_sum = CAP_W'(rb_eff) + CAP_W'(bytes_ff);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         quota_ff <= QUOTA_W'(4);
         cap_ff   <= CAP_W'(65536);
      end else if (csr_we) begin
         case (csr_idx)
            CSR_MAX_PER_IP:   quota_ff <= csr_wdata[QUOTA_W-1:0];
            CSR_MAX_BUFFERED: cap_ff   <= csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         qt_ff    <= '{req_host_port, req_remote_ip_high, req_remote_ip_low,
                       req_peer_port, req_protocol};
         id_ff    <= req_slot_id;
         bytes_ff <= req_byte_count;
      end
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (ctl.scan_clr) begin
         ptr_ff      <= '0;
         ipcnt_ff    <= '0;
         dup_ff      <= 1'b0;
         hit_ff      <= 1'b0;
         free_ok_ff  <= 1'b0;
         hit_ff_idx  <= '0;
         free_idx_ff <= '0;
         free_gen_ff <= '0;
      end else if (ctl.scan_eval) begin
         ptr_ff <= ptr_ff + AW'(1);
         if (eq_ip) ipcnt_ff <= ipcnt_ff + CW'(1);
         if (eq_full && !dup_ff) begin
            dup_ff <= 1'b1;
            if (cmd_ff == CMD_FIND) begin
               hit_ff     <= 1'b1;
               hit_ff_idx <= raddr_ff;
            end
         end
         if (!rv_ff && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= raddr_ff;
            free_gen_ff <= rg_eff;
         end
         if ((cmd_ff == CMD_NEXT) && eq_port && !hit_ff &&
             (!id_ok || ({1'b0, raddr_ff} >= {1'b0, next_start[AW-1:0]} &&
                         next_start < ID_W'(SLOTS)) )) begin
            hit_ff     <= 1'b1;
            hit_ff_idx <= raddr_ff;
         end
      end
   end

   // execute: decide status, report slot, write memories
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         tw_ff     <= '0;
         bw_ff     <= '0;
         gw_ff     <= '0;
         rej_ff    <= '0;
         active_ff <= '0;
      end else if (ctl.exec) begin
         rep_ff <= 1'b0;
         st_ff  <= ST_BAD_SLOT;
         case (cmd_ff)
            CMD_CLAIM: begin
               if (dup_ff) begin
                  st_ff <= ST_DUP; rej_ff <= rej_ff + REJ_W'(1);
               end else if ({{(32-CW){1'b0}}, ipcnt_ff} >= {25'd0, quota_ff}) begin
                  st_ff <= ST_QUOTA; rej_ff <= rej_ff + REJ_W'(1);
               end else if (!free_ok_ff) begin
                  st_ff <= ST_FULL; rej_ff <= rej_ff + REJ_W'(1);
               end else begin
                  st_ff      <= ST_OK;
                  rep_ff     <= 1'b1;
                  rep_idx_ff <= free_idx_ff;
                  tup_mem[free_idx_ff] <= qt_ff;
                  buf_mem[free_idx_ff] <= '0;
                  gen_mem[free_idx_ff] <= free_gen_ff + GEN_W'(1);
                  tw_ff[free_idx_ff]    <= 1'b1;
                  bw_ff[free_idx_ff]    <= 1'b1;
                  gw_ff[free_idx_ff]    <= 1'b1;
                  valid_ff[free_idx_ff] <= 1'b1;
                  active_ff <= active_ff + CW'(1);
               end
            end
            CMD_FIND, CMD_NEXT: begin
               st_ff      <= hit_ff ? ST_OK : ST_NOT_FOUND;
               rep_ff     <= hit_ff;
               rep_idx_ff <= hit_ff_idx;
            end
            CMD_DEPOSIT, CMD_CONSUME, CMD_RELEASE, CMD_READ: begin
               if (id_ok) begin
                  rep_ff     <= 1'b1;
                  rep_idx_ff <= id_a;
                  st_ff      <= ST_OK;
                  case (cmd_ff)
                     CMD_DEPOSIT: begin
                        if (!rv_ff) begin
                           st_ff <= ST_BAD_SLOT;
                        end else if (dep_sum >= cap_sat) begin
                           st_ff  <= ST_OVER_CAP;
                           rej_ff <= rej_ff + REJ_W'(1);
                        end else begin
                           buf_mem[id_a] <= dep_sum[BUF_W-1:0];
                           bw_ff[id_a]   <= 1'b1;
                        end
                     end
                     CMD_CONSUME: begin
                        buf_mem[id_a] <= (BUF_W'(bytes_ff) > rb_eff) ? '0
                                         : rb_eff - BUF_W'(bytes_ff);
                        bw_ff[id_a]   <= 1'b1;
                     end
                     CMD_RELEASE: begin
                        valid_ff[id_a] <= 1'b0;
                        if (rv_ff) active_ff <= active_ff - CW'(1);
                     end
                     default: begin
                        if (!rv_ff) st_ff <= ST_BAD_SLOT;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.respond) begin
         rsp_status         <= st_ff;
         rsp_slot_index     <= rep_ff ? ID_W'(rep_idx_ff) : ID_W'(NONE);
         rsp_entry_host_port   <= (rep_ff && rv_ff) ? rt_eff.lp : '0;
         rsp_entry_ip_high     <= (rep_ff && rv_ff) ? rt_eff.ih : '0;
         rsp_entry_ip_low      <= (rep_ff && rv_ff) ? rt_eff.il : '0;
         rsp_entry_peer_port   <= (rep_ff && rv_ff) ? rt_eff.rp : '0;
         rsp_entry_protocol    <= (rep_ff && rv_ff) ? rt_eff.pr : '0;
         rsp_buffered_level    <= rep_ff ? rb_eff : '0;
         rsp_slot_generation   <= rep_ff ? rg_eff : '0;
         rsp_active_slots   <= ID_W'(active_ff);
         rsp_rejected_total <= rej_ff;
      end
   end

endmodule

// ===== hdl/connection_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// connection_slot_table_top
// ipv6 connection slot table: claim, find, deposit, consume, release, read
// ----------------------------------------------------------------------------
// claim, find exact and next on port scan every slot of the slot memory, reading
//   then evaluating one slot at a time, before execute, final read and respond
// other commands read the addressed slot, then execute, final read and respond
// one command at a time: start is taken only while busy is low
// rsp_valid marks a one-cycle beat; the receiver cannot stall it
// reset (synchronous, active high) frees all slots and loads register defaults
module connection_slot_table_top
   import cst_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [PORT_W-1:0]    req_host_port,
   input  logic [IP_W-1:0]      req_remote_ip_high,
   input  logic [IP_W-1:0]      req_remote_ip_low,
   input  logic [PORT_W-1:0]    req_peer_port,
   input  logic [PROTO_W-1:0]   req_protocol,
   input  logic [ID_W-1:0]      req_slot_id,
   input  logic [BYTES_W-1:0]   req_byte_count,
   // response
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ID_W-1:0]      rsp_slot_index,
   output logic [PORT_W-1:0]    rsp_entry_host_port,
   output logic [IP_W-1:0]      rsp_entry_ip_high,
   output logic [IP_W-1:0]      rsp_entry_ip_low,
   output logic [PORT_W-1:0]    rsp_entry_peer_port,
   output logic [PROTO_W-1:0]   rsp_entry_protocol,
   output logic [BUF_W-1:0]     rsp_buffered_level,
   output logic [GEN_W-1:0]     rsp_slot_generation,
   output logic [ID_W-1:0]      rsp_active_slots,
   output logic [REJ_W-1:0]     rsp_rejected_total,
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CSR_W-1:0]     csr_wdata
);

   ctl_type ctl;   // sequencer commands
   sts_type sts;   // datapath status

   // sequencer: idle, decode, scan loop or addressed read, execute, final read, respond
   cst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl),
      .sts   (sts)
   );

   // slot store and compare logic
   cst_dp #(.SLOTS(SLOTS)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .ctl                   (ctl),
      .sts                   (sts),
      .csr_we                (csr_we),
      .csr_idx               (csr_idx),
      .csr_wdata             (csr_wdata),
      .req_command           (req_command),
      .req_host_port         (req_host_port),
      .req_remote_ip_high    (req_remote_ip_high),
      .req_remote_ip_low     (req_remote_ip_low),
      .req_peer_port         (req_peer_port),
      .req_protocol          (req_protocol),
      .req_slot_id           (req_slot_id),
      .req_byte_count        (req_byte_count),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_entry_host_port   (rsp_entry_host_port),
      .rsp_entry_ip_high     (rsp_entry_ip_high),
      .rsp_entry_ip_low      (rsp_entry_ip_low),
      .rsp_entry_peer_port   (rsp_entry_peer_port),
      .rsp_entry_protocol    (rsp_entry_protocol),
      .rsp_buffered_level    (rsp_buffered_level),
      .rsp_slot_generation   (rsp_slot_generation),
      .rsp_active_slots      (rsp_active_slots),
      .rsp_rejected_total    (rsp_rejected_total)
   );

endmodule
